// File: src/hsvs_pkg.sv
// Shared constants and types for the HSV saturation scaling core.
// No dependencies.
package hsvs_pkg;

  localparam int COMPONENT_BITS_DEF = 8;
  localparam int FRAC_BITS          = 16;
  localparam int GAIN_BITS          = 16;
  localparam int GAIN_FRAC_BITS     = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  // hue sextants
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

// File: src/hsvs_pix_if.sv
// Valid/ready pixel stream interfaces for the HSV saturation scaling core.
// Depends on hsvs_pkg for the default component width.
interface hsvs_pix_in_if #(parameter int W = hsvs_pkg::COMPONENT_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface hsvs_pix_out_if #(parameter int W = hsvs_pkg::COMPONENT_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: src/hsv_saturation_scale_core.sv
// HSV saturation scaling core: RGB in, saturation-scaled RGB out.
// Throughput one pixel per cycle when the output is not stalled; the two 17-step
// restoring dividers (saturation and hue fraction) set the pipeline depth.
// Each stage stalls only when full and blocked downstream.
// rst_ni (async, active low) clears all valid bits; gain resets to 1.0.
// Depends on hsvs_pkg and hsvs_pix_if.
module hsv_saturation_scale_core #(
  parameter int COMPONENT_BITS = hsvs_pkg::COMPONENT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           saturation_gain_we_i,
  input  logic [hsvs_pkg::GAIN_BITS-1:0] saturation_gain_i,
  hsvs_pix_in_if.sink                    pix_i,
  hsvs_pix_out_if.source                 pix_o
);

  localparam int W     = COMPONENT_BITS;
  localparam int FB    = hsvs_pkg::FRAC_BITS;
  localparam int GB    = hsvs_pkg::GAIN_BITS;
  localparam int Q     = FB + 1;
  localparam int DIV_N = Q;
  localparam int ST_G  = DIV_N + 1;
  localparam int ST_C  = DIV_N + 2;
  localparam int ST_F  = DIV_N + 3;
  localparam int ST_P  = DIV_N + 4;
  localparam int ST_O  = DIV_N + 5;
  localparam int N_ST  = DIV_N + 6;
  localparam int PW    = Q + GB;
  localparam int SCW   = PW - hsvs_pkg::GAIN_FRAC_BITS;
  localparam logic [Q-1:0] ONE = {1'b1, {FB{1'b0}}};

  logic [GB-1:0] gain_q;
  logic v_q [N_ST];
  logic rdy [N_ST+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= hsvs_pkg::GAIN_RESET;
    end else if (saturation_gain_we_i) begin
      gain_q <= saturation_gain_i;
    end
  end

  // per-stage ready chain
  assign rdy[N_ST] = pix_o.ready;
  for (genvar k = 0; k < N_ST; k++) begin : g_vld
    assign rdy[k] = !v_q[k] || rdy[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        if (k == 0) begin
          v_q[k] <= pix_i.valid;
        end else begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end
  assign pix_i.ready = rdy[0];

  // divider pipeline: stage 0 is the front end, stages 1..DIV_N are steps
  logic [W-1:0]          mx_q    [DIV_N+1];
  logic [W-1:0]          dh_q    [DIV_N+1];
  logic [W:0]            rs_q    [DIV_N+1];
  logic [W:0]            rh_q    [DIV_N+1];
  logic [Q-1:0]          qs_q    [DIV_N+1];
  logic [Q-1:0]          qh_q    [DIV_N+1];
  logic [2:0]            base_q  [DIV_N+1];

  logic [W-1:0] r, g, b, mx_d, mn_d, n_d;
  hsvs_pkg::sector_e base_d;

  always_comb begin
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    mx_d = r;
    mn_d = r;
    if (g > mx_d) mx_d = g;
    if (b > mx_d) mx_d = b;
    if (g < mn_d) mn_d = g;
    if (b < mn_d) mn_d = b;
    if (mx_d == r) begin
      if (g >= b) begin
        base_d = hsvs_pkg::SEC_RED_YEL;
        n_d    = g - b;
      end else begin
        base_d = hsvs_pkg::SEC_MAG_RED;
        n_d    = r - b;
      end
    end else if (mx_d == g) begin
      if (b >= r) begin
        base_d = hsvs_pkg::SEC_GRN_CYN;
        n_d    = b - r;
      end else begin
        base_d = hsvs_pkg::SEC_YEL_GRN;
        n_d    = g - r;
      end
    end else begin
      if (r >= g) begin
        base_d = hsvs_pkg::SEC_BLU_MAG;
        n_d    = r - g;
      end else begin
        base_d = hsvs_pkg::SEC_CYN_BLU;
        n_d    = b - g;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mx_q[0]   <= mx_d;
      dh_q[0]   <= mx_d - mn_d;
      rs_q[0]   <= {1'b0, mx_d - mn_d};
      rh_q[0]   <= {1'b0, n_d};
      qs_q[0]   <= '0;
      qh_q[0]   <= '0;
      base_q[0] <= base_d;
    end
  end

  for (genvar k = 1; k <= DIV_N; k++) begin : g_div
    logic [W:0] ts, th, ns, nh;
    logic       bs, bh;
    if (k == 1) begin : g_first
      assign ts = rs_q[k-1];
      assign th = rh_q[k-1];
    end else begin : g_next
      assign ts = {rs_q[k-1][W-1:0], 1'b0};
      assign th = {rh_q[k-1][W-1:0], 1'b0};
    end
    assign bs = ts >= {1'b0, mx_q[k-1]};
    assign bh = th >= {1'b0, dh_q[k-1]};
    assign ns = bs ? ts - {1'b0, mx_q[k-1]} : ts;
    assign nh = bh ? th - {1'b0, dh_q[k-1]} : th;
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        mx_q[k]   <= mx_q[k-1];
        dh_q[k]   <= dh_q[k-1];
        rs_q[k]   <= ns;
        rh_q[k]   <= nh;
        qs_q[k]   <= {qs_q[k-1][Q-2:0], bs};
        qh_q[k]   <= {qh_q[k-1][Q-2:0], bh};
        base_q[k] <= base_q[k-1];
      end
    end
  end

  // gain product, sector wrap
  logic [PW-1:0]     prod_q;
  logic [W-1:0]      mx_g_q, mx_c_q, mx_f_q, mx_p_q;
  logic [2:0]        sec_g_q, sec_c_q, sec_f_q, sec_p_q;
  logic [FB-1:0]     frac_g_q, frac_c_q;
  logic [Q-1:0]      s_dv;
  logic [2:0]        sec_d;

  always_comb begin
    s_dv  = (mx_q[DIV_N] == '0) ? '0 : qs_q[DIV_N];
    sec_d = base_q[DIV_N];
    if (qh_q[DIV_N][FB]) begin
      if (base_q[DIV_N] == hsvs_pkg::SEC_MAG_RED) begin
        sec_d = hsvs_pkg::SEC_RED_YEL;
      end else begin
        sec_d = base_q[DIV_N] + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_G]) begin
      prod_q   <= PW'(s_dv) * PW'(gain_q);
      mx_g_q   <= mx_q[DIV_N];
      sec_g_q  <= sec_d;
      frac_g_q <= qh_q[DIV_N][FB-1:0];
    end
  end

  // clamp
  logic [SCW-1:0] sc;
  logic [Q-1:0]   ss_q;
  assign sc = prod_q[PW-1:hsvs_pkg::GAIN_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_C]) begin
      ss_q     <= (sc > SCW'(ONE)) ? ONE : sc[Q-1:0];
      mx_c_q   <= mx_g_q;
      sec_c_q  <= sec_g_q;
      frac_c_q <= frac_g_q;
    end
  end

  // scale factors
  logic [2*Q-1:0] pq, pt;
  logic [Q-1:0]   fp_q, fq_q, ft_q;
  assign pq = (2*Q)'(ss_q) * (2*Q)'(frac_c_q);
  assign pt = (2*Q)'(ss_q) * (2*Q)'(ONE - {1'b0, frac_c_q});

  always_ff @(posedge clk_i) begin
    if (rdy[ST_F]) begin
      fp_q    <= ONE - ss_q;
      fq_q    <= ONE - pq[FB+Q-1:FB];
      ft_q    <= ONE - pt[FB+Q-1:FB];
      mx_f_q  <= mx_c_q;
      sec_f_q <= sec_c_q;
    end
  end

  // component products
  logic [W+Q-1:0] mp, mq, mt;
  logic [W-1:0]   p_q, q_q, t_q;
  assign mp = (W+Q)'(mx_f_q) * (W+Q)'(fp_q);
  assign mq = (W+Q)'(mx_f_q) * (W+Q)'(fq_q);
  assign mt = (W+Q)'(mx_f_q) * (W+Q)'(ft_q);

  always_ff @(posedge clk_i) begin
    if (rdy[ST_P]) begin
      p_q     <= mp[FB+W-1:FB];
      q_q     <= mq[FB+W-1:FB];
      t_q     <= mt[FB+W-1:FB];
      mx_p_q  <= mx_f_q;
      sec_p_q <= sec_f_q;
    end
  end

  // sextant select, output register
  logic [W-1:0] ro_d, go_d, bo_d, ro_q, go_q, bo_q;

  always_comb begin
    case (sec_p_q)
      hsvs_pkg::SEC_RED_YEL: begin ro_d = mx_p_q; go_d = t_q;    bo_d = p_q;    end
      hsvs_pkg::SEC_YEL_GRN: begin ro_d = q_q;    go_d = mx_p_q; bo_d = p_q;    end
      hsvs_pkg::SEC_GRN_CYN: begin ro_d = p_q;    go_d = mx_p_q; bo_d = t_q;    end
      hsvs_pkg::SEC_CYN_BLU: begin ro_d = p_q;    go_d = q_q;    bo_d = mx_p_q; end
      hsvs_pkg::SEC_BLU_MAG: begin ro_d = t_q;    go_d = p_q;    bo_d = mx_p_q; end
      default:               begin ro_d = mx_p_q; go_d = p_q;    bo_d = q_q;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_O]) begin
      ro_q <= ro_d;
      go_q <= go_d;
      bo_q <= bo_d;
    end
  end

  assign pix_o.valid     = v_q[ST_O];
  assign pix_o.red_out   = ro_q;
  assign pix_o.green_out = go_q;
  assign pix_o.blue_out  = bo_q;

endmodule
